### hdl/pvo8_pkg.sv
// shared types, constants and helpers for the plurality voter
`default_nettype none

package pvo8_pkg;

	localparam int NumVotes = 8;
	localparam int LabelW   = 8;
	localparam int CntW     = $clog2(NumVotes + 1);

	typedef logic [LabelW-1:0] label_t;
	typedef logic [CntW-1:0]   cnt_t;
	typedef label_t [NumVotes-1:0] label_arr_t;
	typedef cnt_t   [NumVotes-1:0] cnt_arr_t;

	typedef struct packed {
		label_t vote_0;
		label_t vote_1;
		label_t vote_2;
		label_t vote_3;
		label_t vote_4;
		label_t vote_5;
		label_t vote_6;
		label_t vote_7;
		label_t second_label;
	} ballot_t;

	typedef struct packed {
		label_t best_label;
		logic   use_votes;
		label_t second_label_out;
	} verdict_t;

	// one contender of the argmax tree
	typedef struct packed {
		label_t lab;
		cnt_t   cnt;
	} cand_t;

	function automatic label_arr_t unpack_votes(input ballot_t b);
		label_arr_t v;
		v[0] = b.vote_0;
		v[1] = b.vote_1;
		v[2] = b.vote_2;
		v[3] = b.vote_3;
		v[4] = b.vote_4;
		v[5] = b.vote_5;
		v[6] = b.vote_6;
		v[7] = b.vote_7;
		return v;
	endfunction

	// earlier contender keeps the win on a tie
	function automatic cand_t pick(input cand_t early, input cand_t late);
		return (late.cnt > early.cnt) ? late : early;
	endfunction

endpackage

`default_nettype wire

### hdl/pvo8_count.sv
// stage two: per-position vote tally over the masked prefix
`default_nettype none

module pvo8_count (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire pvo8_pkg::label_arr_t lab,
	input  wire pvo8_pkg::label_t     second,
	output pvo8_pkg::label_arr_t      lab_s2,
	output pvo8_pkg::cnt_arr_t        cnt_s2,
	output pvo8_pkg::label_t          second_s2
);

	pvo8_pkg::cnt_arr_t cnt;

	always_comb begin
		for (int i = 0; i < pvo8_pkg::NumVotes; i++) begin
			cnt[i] = '0;
			for (int j = 0; j < pvo8_pkg::NumVotes; j++) begin
				cnt[i] = cnt[i] + pvo8_pkg::CntW'((lab[j] != '0) && (lab[j] == lab[i]));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lab_s2    <= lab;
			cnt_s2    <= cnt;
			second_s2 <= second;
		end
	end

endmodule

`default_nettype wire

### hdl/pvo8_select.sv
// stage three: first two levels of the earliest-max tree
`default_nettype none

module pvo8_select (
	input  wire logic                 clk,
	input  wire logic                 en,
	input  wire pvo8_pkg::label_arr_t lab,
	input  wire pvo8_pkg::cnt_arr_t   cnt,
	input  wire pvo8_pkg::label_t     second,
	output pvo8_pkg::cand_t           lo_s3,
	output pvo8_pkg::cand_t           hi_s3,
	output pvo8_pkg::label_t          second_s3
);

	pvo8_pkg::cand_t leaf [pvo8_pkg::NumVotes];
	pvo8_pkg::cand_t lvl1 [pvo8_pkg::NumVotes/2];
	pvo8_pkg::cand_t lo, hi;

	always_comb begin
		for (int i = 0; i < pvo8_pkg::NumVotes; i++) begin
			leaf[i].lab = lab[i];
			leaf[i].cnt = cnt[i];
		end
		for (int i = 0; i < pvo8_pkg::NumVotes/2; i++) begin
			lvl1[i] = pvo8_pkg::pick(leaf[2*i], leaf[2*i+1]);
		end
		lo = pvo8_pkg::pick(lvl1[0], lvl1[1]);
		hi = pvo8_pkg::pick(lvl1[2], lvl1[3]);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s3     <= lo;
			hi_s3     <= hi;
			second_s3 <= second;
		end
	end

endmodule

`default_nettype wire

### hdl/pvo8_reconcile.sv
// stage four: final pick and merge with the second-source label
`default_nettype none

module pvo8_reconcile (
	input  wire logic             clk,
	input  wire logic             en,
	input  wire pvo8_pkg::cand_t  lo,
	input  wire pvo8_pkg::cand_t  hi,
	input  wire pvo8_pkg::label_t second,
	output pvo8_pkg::verdict_t    verdict_s4
);

	pvo8_pkg::cand_t  win;
	pvo8_pkg::verdict_t res;

	always_comb begin
		win = pvo8_pkg::pick(lo, hi);
		if (second == '0) begin
			res.best_label       = win.lab;
			res.use_votes        = 1'b1;
			res.second_label_out = '0;
		end else if (win.lab == '0) begin
			res.best_label       = second;
			res.use_votes        = 1'b0;
			res.second_label_out = second;
		end else if (win.lab != second) begin
			// disagreement drops the second source
			res.best_label       = win.lab;
			res.use_votes        = 1'b1;
			res.second_label_out = '0;
		end else begin
			res.best_label       = win.lab;
			res.use_votes        = 1'b0;
			res.second_label_out = second;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			verdict_s4 <= res;
		end
	end

endmodule

`default_nettype wire

### hdl/plurality_vote_of_eight.sv
// top level: four-stage plurality voter with second-source reconciliation
//
//   channel   payload     valid           stall
//   ballot    ballot      ballot_valid    ballot_stall
//   verdict   verdict     verdict_valid   verdict_stall
//
// one beat per cycle sustained while verdict_stall stays low
// stages: prefix mask, tally, two tree levels, last pick plus reconcile
// arst_n clears only the stage valid bits, payload registers are not reset
// a stalled verdict holds; bubbles ahead of it still collapse
// ballot_stall follows verdict_stall combinationally when every stage is full
`default_nettype none

module plurality_vote_of_eight (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire pvo8_pkg::ballot_t  ballot,
	input  wire logic               ballot_valid,
	output logic                    ballot_stall,
	output pvo8_pkg::verdict_t      verdict,
	output logic                    verdict_valid,
	input  wire logic               verdict_stall
);

	logic vld_s1, vld_s2, vld_s3, vld_s4;
	logic adv1, adv2, adv3, adv4;

	pvo8_pkg::label_arr_t raw, masked;
	pvo8_pkg::label_arr_t lab_s1, lab_s2;
	pvo8_pkg::label_t     second_s1, second_s2, second_s3;
	pvo8_pkg::cnt_arr_t   cnt_s2;
	pvo8_pkg::cand_t      lo_s3, hi_s3;
	logic                 live;

	assign adv4 = !vld_s4 || !verdict_stall;
	assign adv3 = !vld_s3 || adv4;
	assign adv2 = !vld_s2 || adv3;
	assign adv1 = !vld_s1 || adv2;

	assign ballot_stall  = !adv1;
	assign verdict_valid = vld_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else begin
			if (adv1) vld_s1 <= ballot_valid;
			if (adv2) vld_s2 <= vld_s1;
			if (adv3) vld_s3 <= vld_s2;
			if (adv4) vld_s4 <= vld_s3;
		end
	end

	// votes after the first zero read as zero
	always_comb begin
		raw  = pvo8_pkg::unpack_votes(ballot);
		live = 1'b1;
		for (int i = 0; i < pvo8_pkg::NumVotes; i++) begin
			live      = live && (raw[i] != '0);
			masked[i] = live ? raw[i] : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			lab_s1    <= masked;
			second_s1 <= ballot.second_label;
		end
	end

	pvo8_count u_count (
		.clk       (clk),
		.en        (adv2),
		.lab       (lab_s1),
		.second    (second_s1),
		.lab_s2    (lab_s2),
		.cnt_s2    (cnt_s2),
		.second_s2 (second_s2)
	);

	pvo8_select u_select (
		.clk       (clk),
		.en        (adv3),
		.lab       (lab_s2),
		.cnt       (cnt_s2),
		.second    (second_s2),
		.lo_s3     (lo_s3),
		.hi_s3     (hi_s3),
		.second_s3 (second_s3)
	);

	pvo8_reconcile u_reconcile (
		.clk        (clk),
		.en         (adv4),
		.lo         (lo_s3),
		.hi         (hi_s3),
		.second     (second_s3),
		.verdict_s4 (verdict)
	);

endmodule

`default_nettype wire
